>>> rtl/core/base64url_stream_decoder_core_macros.svh
// Assertion macros shared by the stream decoder RTL.
// Depends on nothing; included by base64url_stream_decoder_core, which carries the assertions.
`ifndef BASE64URL_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64URL_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/b64d_pkg.sv
// Shared types, codes and the character map of the stream decoder.
// Depends on nothing; imported by every module of the decoder.
package b64d_pkg;

  // Character codes
  localparam logic [7:0] CHR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A    = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CHR_DIGIT_0    = 8'h30;
  localparam logic [7:0] CHR_DIGIT_9    = 8'h39;
  localparam logic [7:0] CHR_DASH       = 8'h2D;
  localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHR_PAD        = 8'h3D;

  // Value offsets of the alphabet sections
  localparam logic [5:0] OFS_LOWER      = 6'd26;
  localparam logic [5:0] OFS_DIGIT      = 6'd52;
  localparam logic [5:0] VAL_DASH       = 6'd62;
  localparam logic [5:0] VAL_UNDERSCORE = 6'd63;

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
  localparam int          JOB_DEPTH      = 4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_CAPACITY  = 2'd2,
    ST_LONE_TAIL = 2'd3
  } b64d_status_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } b64d_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } b64d_item_t;

  typedef struct packed {
    b64d_kind_t   kind;
    logic [7:0]   data_byte;
    b64d_status_t status;
    logic [15:0]  byte_count;
    logic         end_of_run;
  } b64d_result_t;

  // Work handed from front to back: up to three bytes and an optional summary
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            summary;
    b64d_status_t    status;
    logic [15:0]     base_count;
  } b64d_job_t;

  typedef struct packed {
    logic       is_val;
    logic       is_pad;
    logic [5:0] val;
  } b64d_map_t;

  // Classify one character of the URL-safe alphabet
  function automatic b64d_map_t b64d_map(input logic [7:0] c);
    b64d_map_t m;
    m.is_val = 1'b1;
    m.is_pad = 1'b0;
    m.val    = '0;
    if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
      m.val = 6'(c - CHR_UPPER_A);
    end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
      m.val = 6'(c - CHR_LOWER_A) + OFS_LOWER;
    end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
      m.val = 6'(c - CHR_DIGIT_0) + OFS_DIGIT;
    end else if (c == CHR_DASH) begin
      m.val = VAL_DASH;
    end else if (c == CHR_UNDERSCORE) begin
      m.val = VAL_UNDERSCORE;
    end else if (c == CHR_PAD) begin
      m.is_val = 1'b0;
      m.is_pad = 1'b1;
    end else begin
      m.is_val = 1'b0;
    end
    return m;
  endfunction

endpackage

>>> rtl/core/b64d_front.sv
// Front end: accepts characters, tracks run state and builds output jobs.
// Depends on b64d_pkg.
module b64d_front (
  input  logic                 clk,
  input  logic                 rst,
  input  b64d_pkg::b64d_item_t item,
  input  logic                 accept,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  output b64d_pkg::b64d_job_t  job,
  output logic                 job_push
);
  import b64d_pkg::*;

  logic [15:0]     capacity;
  logic [2:0][5:0] pv;
  logic [1:0]      pcnt;
  logic            pad;
  b64d_status_t    err;
  logic [15:0]     bytes_out;

  b64d_map_t       m;
  logic [2:0][5:0] pv_next;
  logic [1:0]      pcnt_next;
  logic            pad_next;
  b64d_status_t    err_mid;
  b64d_status_t    err_next;
  logic [15:0]     bytes_out_next;
  logic            grp;
  logic [2:0][5:0] src;
  logic [5:0]      v3;
  logic [1:0]      n_req;
  logic [1:0]      n_emit;
  logic [16:0]     sum;
  logic            cap_fail;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Classify the character and update the pending group
  always_comb begin
    m         = b64d_map(item.char_code);
    pv_next   = pv;
    pcnt_next = pcnt;
    pad_next  = pad;
    err_mid   = err;
    grp       = 1'b0;
    if (item.has_char && err == ST_OK && !pad) begin
      if (m.is_pad) begin
        pad_next = 1'b1;
      end else if (!m.is_val) begin
        err_mid = ST_BAD_CHAR;
      end else if (pcnt == 2'd3) begin
        grp       = 1'b1;
        pv_next   = '0;
        pcnt_next = '0;
      end else begin
        pv_next[pcnt] = m.val;
        pcnt_next     = pcnt + 2'd1;
      end
    end
  end

  // Size the emission and check it against capacity
  always_comb begin
    src = grp ? pv : pv_next;
    v3  = grp ? m.val : '0;
    if (grp) begin
      n_req = 2'd3;
    end else if (item.last && err_mid == ST_OK && pcnt_next >= 2'd2) begin
      n_req = pcnt_next - 2'd1;
    end else begin
      n_req = 2'd0;
    end
    sum            = {1'b0, bytes_out} + {15'b0, n_req};
    cap_fail       = sum > {1'b0, capacity};
    n_emit         = '0;
    err_next       = err_mid;
    bytes_out_next = bytes_out;
    if (n_req != 2'd0) begin
      if (cap_fail) begin
        err_next = ST_CAPACITY;
      end else begin
        n_emit         = n_req;
        bytes_out_next = sum[15:0];
      end
    end
    if (item.last && err_mid == ST_OK && pcnt_next == 2'd1) begin
      err_next = ST_LONE_TAIL;
    end
  end

  // Build the job for the back end
  always_comb begin
    job.bytes[0]   = {src[0], src[1][5:4]};
    job.bytes[1]   = {src[1][3:0], src[2][5:2]};
    job.bytes[2]   = {src[2][1:0], v3};
    job.nbytes     = n_emit;
    job.summary    = item.last;
    job.status     = err_next;
    job.base_count = bytes_out;
    job_push       = accept && (n_emit != 2'd0 || item.last);
  end

  // Advance run state; clear it after a summary
  always_ff @(posedge clk) begin
    if (rst) begin
      pv        <= '0;
      pcnt      <= '0;
      pad       <= 1'b0;
      err       <= ST_OK;
      bytes_out <= '0;
    end else if (accept) begin
      if (item.last) begin
        pv        <= '0;
        pcnt      <= '0;
        pad       <= 1'b0;
        err       <= ST_OK;
        bytes_out <= '0;
      end else begin
        pv        <= pv_next;
        pcnt      <= pcnt_next;
        pad       <= pad_next;
        err       <= err_next;
        bytes_out <= bytes_out_next;
      end
    end
  end

endmodule

>>> rtl/core/b64d_job_fifo.sv
// Short job queue between the front and back ends, held in flops.
// Depends on b64d_pkg.
module b64d_job_fifo #(
  parameter int DEPTH = b64d_pkg::JOB_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  b64d_pkg::b64d_job_t wdata,
  output logic                full,
  input  logic                rd,
  output b64d_pkg::b64d_job_t rdata,
  output logic                empty
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_job_t         mem [DEPTH];
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     rptr;
  logic [CW-1:0]     count;
  logic              do_wr;
  logic              do_rd;

  assign full  = count == FULL_CNT;
  assign empty = count == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  // Store the written job
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/b64d_back.sv
// Back end: expands jobs into data and summary results behind an output register.
// Depends on b64d_pkg.
module b64d_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  b64d_pkg::b64d_job_t    q_rdata,
  output logic                   q_rd,
  input  logic                   pop,
  output logic                   empty,
  output b64d_pkg::b64d_result_t result
);
  import b64d_pkg::*;

  logic         job_valid;
  b64d_job_t    job;
  logic [1:0]   idx;
  logic         out_valid;
  b64d_result_t res_next;
  logic         res_last;
  logic         advance;

  // Form the result at the current position of the job
  always_comb begin
    res_next = '0;
    if (idx < job.nbytes) begin
      res_next.kind       = KIND_DATA;
      res_next.status     = ST_OK;
      res_next.byte_count = job.base_count + {14'b0, idx} + 16'd1;
      case (idx)
        2'd0:    res_next.data_byte = job.bytes[0];
        2'd1:    res_next.data_byte = job.bytes[1];
        default: res_next.data_byte = job.bytes[2];
      endcase
      res_last = (idx == job.nbytes - 2'd1) && !job.summary;
    end else begin
      res_next.kind       = KIND_SUMMARY;
      res_next.data_byte  = '0;
      res_next.status     = job.status;
      res_next.byte_count = job.base_count + {14'b0, job.nbytes};
      res_last            = 1'b1;
    end
    res_next.end_of_run = res_last;
  end

  // Move a result when the output register is free or being drained
  assign advance = job_valid && (!out_valid || pop);
  assign q_rd    = !q_empty && (!job_valid || (advance && res_last));
  assign empty   = !out_valid;

  // Hold the current job and its position
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (q_rd) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (advance) begin
      if (res_last) begin
        job_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      job <= q_rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

endmodule

>>> rtl/core/base64url_stream_decoder_core.sv
// URL-safe Base64 stream decoder, one character per input transaction.
// Input side is a queue: push an item while full is low; it is taken at that edge.
// Result side is a queue: while empty is low the oldest result sits on result;
// pop takes it. Each item gives zero to four results: up to three decoded bytes,
// and on an item marked last, tail bytes plus one summary with status and count.
// Configuration: cfg_data is written to the output capacity when cfg_valid is
// high; cfg_ready is always high. Write it only while the decoder is idle.
// The first result of an item passes the job queue, the back end's job register and the output register.
// Throughput: one item per cycle while each item yields at most one result and the
// receiver does not stall; the back end drains one result per cycle unless stalled,
// so the results of an item leave one at a time, and the job queue (QUEUE_DEPTH jobs) absorbs bursts.
// When the receiver stalls, the output register holds, the queue fills, and
// full rises; accepted items are never dropped.
// Reset (rst, synchronous) empties the queue, clears run state, and sets the
// capacity to 65535.
// Depends on b64d_pkg, b64d_front, b64d_job_fifo, b64d_back and the macro header.
`include "base64url_stream_decoder_core_macros.svh"

module base64url_stream_decoder_core #(
  parameter int QUEUE_DEPTH = b64d_pkg::JOB_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  b64d_pkg::b64d_item_t   item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            cfg_data,
  output logic                   empty,
  input  logic                   pop,
  output b64d_pkg::b64d_result_t result
);
  import b64d_pkg::*;

  logic      accept;
  logic      cfg_we;
  b64d_job_t job_in;
  logic      job_push;
  b64d_job_t job_out;
  logic      q_empty;
  logic      q_full;
  logic      q_rd;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign full      = q_full;
  assign accept    = push && !q_full;

  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .accept   (accept),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .job      (job_in),
    .job_push (job_push)
  );

  b64d_job_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_push),
    .wdata (job_in),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (job_out),
    .empty (q_empty)
  );

  b64d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rdata (job_out),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // A summary always closes the results of its item
  `B64D_ASSERT_NOW(a_summary_ends, clk, rst, !empty && result.kind == KIND_SUMMARY, result.end_of_run, "summary result without end_of_run")
  // Data bytes never carry an error status
  `B64D_ASSERT_NOW(a_data_status_ok, clk, rst, !empty && result.kind == KIND_DATA, result.status == ST_OK, "data result with nonzero status")
  // An item marked last always leaves work behind
  `B64D_ASSERT_NEXT(a_last_queued, clk, rst, accept && item.last, !q_empty || !empty, "last item produced no job")

endmodule
